// File: design/bdpc_pkg.sv
// Shared types and constants for the button debounce and press classifier.
`timescale 1ns / 1ps

package bdpc_pkg;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned EVENT_W = 3;

    // Packed stream widths, rounded up to whole bytes
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 40;

    // Register indexes on the configuration port
    localparam logic CFG_DEBOUNCE_TIME   = 1'b0;
    localparam logic CFG_LONG_PRESS_TIME = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_PRESSED  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_SHORT    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_RELEASED = 3'd3;
    localparam logic [EVENT_W-1:0] EV_LONG     = 3'd4;

    // One result from the classifier core
    typedef struct packed {
        logic [EVENT_W-1:0] event_code;
        logic               stable_level;
        logic [TIME_W-1:0]  held_ms;
    } t_result;

endpackage

// File: design/bdpc_core.sv
// Debounce state, configuration registers and press classification logic.
`timescale 1ns / 1ps

module bdpc_core
    import bdpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_step,
    input  logic              i_level,
    input  logic [TIME_W-1:0] i_now_ms,
    output t_result           o_result
);

    logic [CFG_W-1:0]  r_debounce_time;
    logic [CFG_W-1:0]  r_long_press_time;

    logic              r_debounced;
    logic              r_cand_value;
    logic              r_cand_active;
    logic [TIME_W-1:0] r_cand_start;
    logic [TIME_W-1:0] r_press_start;
    logic              r_long_done;

    logic              n_debounced;
    logic              n_cand_value;
    logic              n_cand_active;
    logic [TIME_W-1:0] n_cand_start;
    logic [TIME_W-1:0] n_press_start;
    logic              n_long_done;
    logic [EVENT_W-1:0] w_event;

    logic [TIME_W-1:0] w_cand_age;
    logic [TIME_W-1:0] w_press_age;
    logic              w_accepted;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time   <= DEBOUNCE_RESET;
            r_long_press_time <= LONG_PRESS_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_DEBOUNCE_TIME:   r_debounce_time   <= i_cfg_wdata;
                CFG_LONG_PRESS_TIME: r_long_press_time <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_cand_age = i_now_ms - r_cand_start;

    // Candidate tracking and level acceptance
    always_comb begin
        n_debounced   = r_debounced;
        n_cand_value  = r_cand_value;
        n_cand_active = r_cand_active;
        n_cand_start  = r_cand_start;
        n_press_start = r_press_start;
        n_long_done   = r_long_done;
        w_event       = EV_NONE;
        w_accepted    = 1'b0;
        if (i_level != r_debounced) begin
            if (!r_cand_active || (r_cand_value != i_level)) begin
                n_cand_active = 1'b1;
                n_cand_value  = i_level;
                n_cand_start  = i_now_ms;
            end else if (w_cand_age >= {{(TIME_W-CFG_W){1'b0}}, r_debounce_time}) begin
                w_accepted    = 1'b1;
                n_cand_active = 1'b0;
                n_debounced   = i_level;
                if (i_level) begin
                    n_press_start = i_now_ms;
                    n_long_done   = 1'b0;
                    w_event       = EV_PRESSED;
                end else begin
                    w_event = r_long_done ? EV_RELEASED : EV_SHORT;
                end
            end
        end else begin
            n_cand_active = 1'b0;
        end
        // Long press check, skipped on a step that accepts a level
        if (!w_accepted && r_debounced && !r_long_done &&
                (w_press_age >= {{(TIME_W-CFG_W){1'b0}}, r_long_press_time})) begin
            n_long_done = 1'b1;
            w_event     = EV_LONG;
        end
    end

    assign w_press_age = i_now_ms - r_press_start;

    // Result for this item
    always_comb begin
        o_result.event_code   = w_event;
        o_result.stable_level = n_debounced;
        o_result.held_ms      = n_debounced ? (i_now_ms - n_press_start) : '0;
    end

    // State update, one item per cycle while i_step is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounced   <= 1'b0;
            r_cand_value  <= 1'b0;
            r_cand_active <= 1'b0;
            r_cand_start  <= '0;
            r_press_start <= '0;
            r_long_done   <= 1'b0;
        end else if (i_step) begin
            r_debounced   <= n_debounced;
            r_cand_value  <= n_cand_value;
            r_cand_active <= n_cand_active;
            r_cand_start  <= n_cand_start;
            r_press_start <= n_press_start;
            r_long_done   <= n_long_done;
        end
    end

endmodule

// File: design/button_debounce_press_classifier.sv
// Each input transaction passes through the input register and the combinational core into the output register.
// Throughput: one item per cycle while the output is not stalled; the classifier state updates as each item advances.
// Input register and output register each hold one item, so a stalled output
// still lets one more input transaction in.
// Reset (synchronous, active low) clears both stages, the debounce state and
// restores debounce_time = 20 and long_press_time = 1000.
`timescale 1ns / 1ps

module button_debounce_press_classifier
    import bdpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [0] raw_level, [32:1] now_ms, rest zero
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // [2:0] event_code, [3] stable_level,
                                               // [35:4] held_ms, rest zero
);

    logic              r_in_valid;
    logic              r_in_level;
    logic [TIME_W-1:0] r_in_now;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_result;
    logic              w_advance;
    logic              w_step;

    // Stage moves when the output register is free or being drained
    assign w_advance  = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_advance;
    assign o_s_tready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_level <= i_s_tdata[0];
            r_in_now   <= i_s_tdata[TIME_W:1];
        end
    end

    bdpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_level     (r_in_level),
        .i_now_ms    (r_in_now),
        .o_result    (w_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-TIME_W-EVENT_W-1){1'b0}},
                         r_out.held_ms, r_out.stable_level, r_out.event_code};

`ifndef NO_ASSERTIONS
    // A press event leaves the button down with zero hold time
    a_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_code == EV_PRESSED)
            |-> (r_out.stable_level && r_out.held_ms == '0))
        else $error("pressed event without fresh stable press");

    // Release events leave the button up with zero hold time
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.event_code == EV_SHORT || r_out.event_code == EV_RELEASED))
            |-> (!r_out.stable_level && r_out.held_ms == '0))
        else $error("release event while still pressed");

    // A long press only fires while held
    a_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_code == EV_LONG) |-> r_out.stable_level)
        else $error("long press event while released");

    // A stalled result with a full input stage blocks new transactions
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while pipeline is full");
`endif

endmodule
